@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high
`define TMVF_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("%m: assertion failed");

// Clocked assertion that also runs during reset
`define TMVF_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("%m: assertion failed");

`endif

@@ sv/tmvf_pkg.sv @@
// ---------------------------------------------------------------------------
// tmvf_pkg
// Types, codes and register indexes of the track mode vote filter.
// ---------------------------------------------------------------------------
package tmvf_pkg;

   // Official mode codes
   localparam logic [2:0] MODE_NONE     = 3'd0;
   localparam logic [2:0] MODE_STRAIGHT = 3'd1;
   localparam logic [2:0] MODE_TURN     = 3'd2;
   localparam logic [2:0] MODE_CROSS    = 3'd3;
   localparam logic [2:0] MODE_STR2TRN  = 3'd4;

   // Configuration register indexes
   localparam logic [2:0] CSR_AGREE_AWARD       = 3'd0;
   localparam logic [2:0] CSR_DISAGREE_PENALTY  = 3'd1;
   localparam logic [2:0] CSR_CROSS_HOLD_FRAMES = 3'd2;
   localparam logic [2:0] CSR_SCORE_CEILING     = 3'd3;
   localparam logic [2:0] CSR_PROMOTE_THRESHOLD = 3'd4;
   localparam logic [2:0] CSR_ERROR_THRESHOLD   = 3'd5;
   localparam logic [2:0] CSR_TRANSITION_LIMIT  = 3'd6;

   typedef struct packed {
      logic [5:0]  agree_award;
      logic [5:0]  disagree_penalty;
      logic [7:0]  cross_hold_frames;
      logic [6:0]  score_ceiling;
      logic [6:0]  promote_threshold;
      logic [15:0] error_threshold;
      logic [7:0]  transition_limit;
   } tmvf_cfg_type;

   typedef struct packed {
      logic [2:0] official;
      logic [1:0] candidate;
      logic [6:0] score;            // always 0..127
      logic [7:0] hold_count;
      logic [8:0] transition_count;
   } tmvf_state_type;

   typedef struct packed {
      logic        is_unknown;
      logic [1:0]  observed_mode;
      logic [15:0] fit_error;
   } tmvf_req_type;

endpackage

@@ sv/tmvf_update.sv @@
// ---------------------------------------------------------------------------
// tmvf_update
// Next-state logic of the vote filter for one classified frame.
// ---------------------------------------------------------------------------
module tmvf_update (
   input  tmvf_pkg::tmvf_cfg_type   cfg,
   input  tmvf_pkg::tmvf_state_type cur,
   input  tmvf_pkg::tmvf_req_type   req,
   output tmvf_pkg::tmvf_state_type nxt
);
   import tmvf_pkg::*;

   logic [2:0] obs_mode;
   logic [7:0] agree_sum;
   logic [6:0] agree_score;
   logic [7:0] disagree_diff;
   logic [8:0] trans_step;
   logic [8:0] trans_next;

   assign obs_mode = {1'b0, req.observed_mode};

   // Clamp the raised score at the ceiling
   assign agree_sum   = {1'b0, cur.score} + {2'b00, cfg.agree_award};
   assign agree_score = (agree_sum > {1'b0, cfg.score_ceiling}) ?
                        cfg.score_ceiling : agree_sum[6:0];

   // Lowered score; bit 7 flags a negative result
   assign disagree_diff = {1'b0, cur.score} - {2'b00, cfg.disagree_penalty};

   // Advance the transition counter by one, or two on a high fit error
   assign trans_step = (req.fit_error > cfg.error_threshold) ? 9'd2 : 9'd1;
   assign trans_next = cur.transition_count + trans_step;

   always_comb begin
      nxt = cur;
      if (req.is_unknown) begin
         nxt = cur;
      end else if (cur.official == MODE_NONE) begin
         // First valid frame: adopt the observed class
         nxt.official  = obs_mode;
         nxt.candidate = req.observed_mode;
         nxt.score     = {1'b0, cfg.agree_award};
      end else if (cur.official == MODE_CROSS && cur.hold_count != 8'd0) begin
         // Freeze cross mode while the hold runs
         nxt.hold_count = cur.hold_count - 8'd1;
      end else if (cur.official == MODE_STR2TRN) begin
         if (trans_next > {1'b0, cfg.transition_limit}) begin
            nxt.official         = MODE_TURN;
            nxt.transition_count = 9'd0;
         end else begin
            nxt.transition_count = trans_next;
         end
      end else if (req.observed_mode == cur.candidate) begin
         nxt.score = agree_score;
         if (agree_score > cfg.promote_threshold &&
             cur.official != {1'b0, cur.candidate}) begin
            if (cur.official == MODE_STRAIGHT && {1'b0, cur.candidate} == MODE_TURN) begin
               nxt.official = MODE_STR2TRN;
            end else begin
               nxt.official = {1'b0, cur.candidate};
               if ({1'b0, cur.candidate} == MODE_CROSS) begin
                  nxt.hold_count = cfg.cross_hold_frames;
               end
            end
         end
      end else begin
         // Disagreement: a negative score replaces the candidate
         if (disagree_diff[7]) begin
            nxt.candidate = req.observed_mode;
            nxt.score     = {1'b0, cfg.agree_award};
         end else begin
            nxt.score = disagree_diff[6:0];
         end
      end
   end

endmodule

@@ sv/track_mode_vote_filter_core.sv @@
// ---------------------------------------------------------------------------
// track_mode_vote_filter_core
// Vote filter that settles the official track mode from per-frame classes.
// ---------------------------------------------------------------------------
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_ready  is_unknown, observed_mode, fit_error
// rsp       out        rsp_valid/rsp_ready  official_mode, candidate_mode,
//                                           candidate_score
// csr       in         csr_write_enable     csr_index, csr_write_data
//
// One request per cycle is sustained while responses are taken; each
// request passes through the input register, then the state update into
// the response register. The state update is one pass of short logic.
// Reset clears the pipeline valids and the filter state and loads the
// register defaults. A stalled response holds the input register, and new
// requests are refused only while both stages are full.
// ---------------------------------------------------------------------------
module track_mode_vote_filter_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_is_unknown,
   input  logic [1:0]        req_observed_mode,
   input  logic [15:0]       req_fit_error,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [2:0]        rsp_official_mode,
   output logic [1:0]        rsp_candidate_mode,
   output logic signed [7:0] rsp_candidate_score,
   input  logic              csr_write_enable,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_write_data
);
   import tmvf_pkg::*;

   tmvf_cfg_type   cfg_ff;
   tmvf_state_type state_ff;
   tmvf_state_type state_in;
   tmvf_req_type   req_ff;
   tmvf_req_type   req_in;
   logic           req_valid_ff;
   logic           rsp_valid_ff;
   logic [2:0]     rsp_official_ff;
   logic [1:0]     rsp_candidate_ff;
   logic [6:0]     rsp_score_ff;
   logic           stage_advance;
   logic           req_take;

   assign stage_advance = !rsp_valid_ff || rsp_ready;
   assign req_ready     = !req_valid_ff || stage_advance;
   assign req_take      = req_valid && req_ready;

   assign req_in.is_unknown    = req_is_unknown;
   assign req_in.observed_mode = req_observed_mode;
   assign req_in.fit_error     = req_fit_error;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.agree_award       <= 6'd10;
         cfg_ff.disagree_penalty  <= 6'd30;
         cfg_ff.cross_hold_frames <= 8'd20;
         cfg_ff.score_ceiling     <= 7'd80;
         cfg_ff.promote_threshold <= 7'd30;
         cfg_ff.error_threshold   <= 16'd13;
         cfg_ff.transition_limit  <= 8'd20;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_AGREE_AWARD:       cfg_ff.agree_award       <= csr_write_data[5:0];
            CSR_DISAGREE_PENALTY:  cfg_ff.disagree_penalty  <= csr_write_data[5:0];
            CSR_CROSS_HOLD_FRAMES: cfg_ff.cross_hold_frames <= csr_write_data[7:0];
            CSR_SCORE_CEILING:     cfg_ff.score_ceiling     <= csr_write_data[6:0];
            CSR_PROMOTE_THRESHOLD: cfg_ff.promote_threshold <= csr_write_data[6:0];
            CSR_ERROR_THRESHOLD:   cfg_ff.error_threshold   <= csr_write_data;
            CSR_TRANSITION_LIMIT:  cfg_ff.transition_limit  <= csr_write_data[7:0];
            default: begin
            end
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (req_ready) begin
         req_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         req_ff <= req_in;
      end
   end

   tmvf_update u_update (
      .cfg (cfg_ff),
      .cur (state_ff),
      .req (req_ff),
      .nxt (state_in)
   );

   // Advance the filter state as the request moves to the response stage
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (req_valid_ff && stage_advance) begin
         state_ff <= state_in;
      end
   end

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (stage_advance) begin
         rsp_valid_ff <= req_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_ff && stage_advance) begin
         rsp_official_ff  <= state_in.official;
         rsp_candidate_ff <= state_in.candidate;
         rsp_score_ff     <= state_in.score;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_official_mode   = rsp_official_ff;
   assign rsp_candidate_mode  = rsp_candidate_ff;
   assign rsp_candidate_score = $signed({1'b0, rsp_score_ff});

endmodule

@@ sv/tmvf_checker.sv @@
// ---------------------------------------------------------------------------
// tmvf_checker
// Port-level assertions for the track mode vote filter core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tmvf_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [2:0]        rsp_official_mode,
   input logic [1:0]        rsp_candidate_mode,
   input logic signed [7:0] rsp_candidate_score
);

   // Drop any response after reset
   `TMVF_ASSERT_ALWAYS(a_rsp_empty_after_reset, clock, $past(reset) |-> !rsp_valid)

   // A request taken into an empty output shows a response once it has passed the input and response registers
   `TMVF_ASSERT(a_rsp_latency, clock, reset, (req_valid && req_ready && !rsp_valid) |-> ##2 rsp_valid)

   // The vote score never goes negative
   `TMVF_ASSERT(a_score_nonneg, clock, reset, rsp_valid |-> !rsp_candidate_score[7])

   // A stalled response holds its payload
   `TMVF_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_official_mode) && $stable(rsp_candidate_mode) && $stable(rsp_candidate_score)))

endmodule

bind track_mode_vote_filter_core tmvf_checker u_tmvf_checker (
   .clock               (clock),
   .reset               (reset),
   .req_valid           (req_valid),
   .req_ready           (req_ready),
   .rsp_valid           (rsp_valid),
   .rsp_ready           (rsp_ready),
   .rsp_official_mode   (rsp_official_mode),
   .rsp_candidate_mode  (rsp_candidate_mode),
   .rsp_candidate_score (rsp_candidate_score)
);

@@ bench/testbench.sv @@
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for track_mode_vote_filter_core. It drives frames over
// the request channel with random valid gaps and response stalls. A
// scoreboard mirrors the vote filter state and the register file, and checks
// every response in order. The run covers several register settings: reset
// values, all zeros, near maximum, an award above the ceiling, and random.
// ---------------------------------------------------------------------------
module testbench;
   import tmvf_pkg::*;

   localparam int CYCLE_LIMIT      = 200000;
   localparam int HOLD_OFF_CYCLES  = 64;
   localparam int PRESSURE_SPACING = 350;
   localparam int PHASE_FRAMES     = 170;
   localparam int SETTLE_CYCLES    = 8;

   typedef struct packed {
      logic [2:0] official_mode;
      logic [1:0] candidate_mode;
      logic [7:0] candidate_score;
   } mode_report_type;

   // Mirror of the vote filter: registers, state and pending responses
   class vote_scoreboard_type;
      tmvf_cfg_type     cfg;
      logic [2:0]       official;
      logic [1:0]       candidate;
      int               score;
      logic [7:0]       hold_count;
      int unsigned      trans_count;
      mode_report_type  pending_reports[$];
      int               mismatches;
      int               checked;

      function new();
         cfg.agree_award       = 6'd10;
         cfg.disagree_penalty  = 6'd30;
         cfg.cross_hold_frames = 8'd20;
         cfg.score_ceiling     = 7'd80;
         cfg.promote_threshold = 7'd30;
         cfg.error_threshold   = 16'd13;
         cfg.transition_limit  = 8'd20;
         official    = MODE_NONE;
         candidate   = 2'd0;
         score       = 0;
         hold_count  = 8'd0;
         trans_count = 0;
         mismatches  = 0;
         checked     = 0;
      endfunction

      function void set_register(logic [2:0] index, logic [15:0] value);
         case (index)
            CSR_AGREE_AWARD:       cfg.agree_award       = value[5:0];
            CSR_DISAGREE_PENALTY:  cfg.disagree_penalty  = value[5:0];
            CSR_CROSS_HOLD_FRAMES: cfg.cross_hold_frames = value[7:0];
            CSR_SCORE_CEILING:     cfg.score_ceiling     = value[6:0];
            CSR_PROMOTE_THRESHOLD: cfg.promote_threshold = value[6:0];
            CSR_ERROR_THRESHOLD:   cfg.error_threshold   = value;
            CSR_TRANSITION_LIMIT:  cfg.transition_limit  = value[7:0];
            default: ;
         endcase
      endfunction

      // Advance the filter by one accepted request and queue its response
      function void note_request(logic unknown, logic [1:0] observed, logic [15:0] fit_error);
         mode_report_type view;
         logic [2:0]      cand_wide;
         cand_wide = {1'b0, candidate};
         if (!unknown) begin
            if (official == MODE_NONE) begin
               // first usable frame adopts its class, no vote
               official  = {1'b0, observed};
               candidate = observed;
               score     = int'(cfg.agree_award);
            end else if (official == MODE_CROSS && hold_count != 8'd0) begin
               hold_count = hold_count - 8'd1;
            end else if (official == MODE_STR2TRN) begin
               trans_count += (fit_error > cfg.error_threshold) ? 2 : 1;
               if (trans_count > int'(cfg.transition_limit)) begin
                  official    = MODE_TURN;
                  trans_count = 0;
               end
            end else if (observed == candidate) begin
               score += int'(cfg.agree_award);
               if (score > int'(cfg.score_ceiling)) score = int'(cfg.score_ceiling);
               if (score > int'(cfg.promote_threshold) && official != cand_wide) begin
                  if (official == MODE_STRAIGHT && cand_wide == MODE_TURN) begin
                     official = MODE_STR2TRN;
                  end else begin
                     official = cand_wide;
                     if (official == MODE_CROSS) hold_count = cfg.cross_hold_frames;
                  end
               end
            end else begin
               score -= int'(cfg.disagree_penalty);
               if (score < 0) begin
                  candidate = observed;
                  score     = int'(cfg.agree_award);
               end
            end
         end
         view.official_mode   = official;
         view.candidate_mode  = candidate;
         view.candidate_score = score[7:0];
         pending_reports.push_back(view);
      endfunction

      task report_mismatch(string what);
         if (mismatches < 50) $display("MISMATCH: %s", what);
         mismatches++;
      endtask

      // Compare one accepted response with the oldest pending one
      task check_response(logic [2:0] off, logic [1:0] cand, logic [7:0] scr);
         mode_report_type want;
         if (pending_reports.size() == 0) begin
            report_mismatch($sformatf("response with no request pending (mode %0d)", off));
            return;
         end
         want = pending_reports.pop_front();
         checked++;
         if (off !== want.official_mode)
            report_mismatch($sformatf("response %0d official_mode %0d, want %0d",
                                      checked, off, want.official_mode));
         if (cand !== want.candidate_mode)
            report_mismatch($sformatf("response %0d candidate_mode %0d, want %0d",
                                      checked, cand, want.candidate_mode));
         if (scr !== want.candidate_score)
            report_mismatch($sformatf("response %0d candidate_score %0d, want %0d",
                                      checked, scr, want.candidate_score));
      endtask
   endclass

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic              req_is_unknown;
   logic [1:0]        req_observed_mode;
   logic [15:0]       req_fit_error;
   logic              rsp_valid;
   logic              rsp_ready;
   logic [2:0]        rsp_official_mode;
   logic [1:0]        rsp_candidate_mode;
   logic signed [7:0] rsp_candidate_score;
   logic              csr_write_enable;
   logic [2:0]        csr_index;
   logic [15:0]       csr_write_data;

   vote_scoreboard_type sb;
   int  req_count;
   int  cycle_count;
   int  phase_count;
   int  hold_off_count;
   int  next_pressure_mark;
   int  hold_off_left;
   int  rsp_burst_left;
   bit  idle_enabled;

   track_mode_vote_filter_core dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_is_unknown      (req_is_unknown),
      .req_observed_mode   (req_observed_mode),
      .req_fit_error       (req_fit_error),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_official_mode   (rsp_official_mode),
      .rsp_candidate_mode  (rsp_candidate_mode),
      .rsp_candidate_score (rsp_candidate_score),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   // Clock
   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Watchdog
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("track_mode_vote_filter_core verification failed");
         $finish;
      end
   end

   // Sample both handshakes at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_request(req_is_unknown, req_observed_mode, req_fit_error);
            req_count++;
         end
         if (rsp_valid && rsp_ready)
            sb.check_response(rsp_official_mode, rsp_candidate_mode, rsp_candidate_score);
      end
   end

   // Response side: random stall bursts plus a periodic long hold-off
   initial begin
      rsp_ready          = 1'b0;
      hold_off_left      = 0;
      rsp_burst_left     = 0;
      hold_off_count     = 0;
      next_pressure_mark = 300;
      forever begin
         @(negedge clock);
         // Drop all receiver idling in the last part of the run
         if (!idle_enabled) begin
            hold_off_left  = 0;
            rsp_burst_left = 0;
         end
         if (idle_enabled && hold_off_left == 0 && req_count >= next_pressure_mark) begin
            hold_off_left = HOLD_OFF_CYCLES;
            next_pressure_mark += PRESSURE_SPACING;
            hold_off_count++;
         end
         if (hold_off_left > 0) begin
            hold_off_left--;
            rsp_ready <= 1'b0;
         end else if (rsp_burst_left > 0) begin
            rsp_burst_left--;
            rsp_ready <= 1'b0;
         end else if (idle_enabled && $urandom_range(0, 5) == 0) begin
            rsp_burst_left = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Write one register; call at a falling edge
   task csr_write(logic [2:0] index, logic [15:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= value;
      sb.set_register(index, value);
      @(negedge clock);
   endtask

   task apply_settings(tmvf_cfg_type c);
      csr_write(CSR_AGREE_AWARD,       16'(c.agree_award));
      csr_write(CSR_DISAGREE_PENALTY,  16'(c.disagree_penalty));
      csr_write(CSR_CROSS_HOLD_FRAMES, 16'(c.cross_hold_frames));
      csr_write(CSR_SCORE_CEILING,     16'(c.score_ceiling));
      csr_write(CSR_PROMOTE_THRESHOLD, 16'(c.promote_threshold));
      csr_write(CSR_ERROR_THRESHOLD,   c.error_threshold);
      csr_write(CSR_TRANSITION_LIMIT,  16'(c.transition_limit));
      csr_write_enable <= 1'b0;
      phase_count++;
   endtask

   // Offer one frame, hold it until accepted, then maybe leave a gap
   task send_frame(logic unknown, logic [1:0] observed, logic [15:0] fit_error);
      int count_at_offer;
      int gap;
      count_at_offer = req_count;
      req_valid         <= 1'b1;
      req_is_unknown    <= unknown;
      req_observed_mode <= observed;
      req_fit_error     <= fit_error;
      @(negedge clock);
      while (req_count == count_at_offer) @(negedge clock);
      if (idle_enabled && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 6);
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Drop valid and wait for every pending response
   task drain;
      req_valid <= 1'b0;
      while (sb.pending_reports.size() != 0) @(negedge clock);
   endtask

   // Fit error: wide random, near the threshold, extremes, or small
   function logic [15:0] pick_fit_error();
      int near;
      case ($urandom_range(0, 3))
         0: return 16'($urandom);
         1: begin
            near = int'(sb.cfg.error_threshold) + int'($urandom_range(0, 4)) - 2;
            if (near < 0) near = 0;
            if (near > 65535) near = 65535;
            return 16'(near);
         end
         2: return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         default: return 16'($urandom_range(0, 40));
      endcase
   endfunction

   // Mostly runs of one class with sparse noise, sometimes pure noise
   task run_random_traffic(int frames);
      int         sent;
      int         run_len;
      int         pick;
      logic [1:0] run_mode;
      logic       unknown;
      sent = 0;
      while (sent < frames) begin
         if ($urandom_range(0, 4) != 0) begin
            run_mode = 2'($urandom_range(1, 3));
            run_len  = $urandom_range(2, 30);
            for (int i = 0; i < run_len && sent < frames; i++) begin
               pick = $urandom_range(0, 19);
               if (pick == 0) begin
                  send_frame(1'b1, 2'($urandom), pick_fit_error());
               end else begin
                  send_frame(1'b0, (pick == 1) ? 2'($urandom) : run_mode, pick_fit_error());
                  sent++;
               end
            end
         end else begin
            run_len = $urandom_range(1, 8);
            for (int i = 0; i < run_len && sent < frames; i++) begin
               unknown = ($urandom_range(0, 3) == 0);
               send_frame(unknown, 2'($urandom), pick_fit_error());
               if (!unknown) sent++;
            end
         end
      end
   endtask

   function tmvf_cfg_type random_settings();
      tmvf_cfg_type c;
      c.agree_award       = 6'($urandom_range(0, 63));
      c.disagree_penalty  = 6'($urandom_range(0, 63));
      c.cross_hold_frames = 8'($urandom_range(0, 255));
      c.score_ceiling     = 7'($urandom_range(0, 127));
      c.promote_threshold = 7'($urandom_range(0, 127));
      c.error_threshold   = 16'($urandom);
      c.transition_limit  = 8'($urandom_range(0, 255));
      return c;
   endfunction

   // Main sequence
   initial begin
      tmvf_cfg_type c;
      sb                = new();
      req_count         = 0;
      phase_count       = 0;
      idle_enabled      = 1'b1;
      reset             = 1'b1;
      req_valid         = 1'b0;
      req_is_unknown    = 1'b0;
      req_observed_mode = 2'd0;
      req_fit_error     = 16'd0;
      csr_write_enable  = 1'b0;
      csr_index         = CSR_AGREE_AWARD;
      csr_write_data    = 16'd0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: short hold and transition limit so every path fits
      c = '{6'd10, 6'd30, 8'd2, 7'd80, 7'd30, 16'd13, 8'd4};
      apply_settings(c);
      send_frame(1'b1, 2'd2, 16'hFFFF);                // ignored frame before any mode
      send_frame(1'b0, 2'd0, 16'h0000);                // class zero leaves mode unset
      send_frame(1'b0, MODE_STRAIGHT[1:0], 16'hFFFF);  // first usable frame
      repeat (4) send_frame(1'b0, MODE_STRAIGHT[1:0], 16'd5);
      repeat (2) send_frame(1'b0, MODE_TURN[1:0], 16'd5);   // candidate replaced
      repeat (3) send_frame(1'b0, MODE_TURN[1:0], 16'd5);   // enters straight-to-turn
      send_frame(1'b0, MODE_TURN[1:0], 16'hFFFF);           // double step
      send_frame(1'b0, MODE_CROSS[1:0], 16'd13);            // error at threshold
      send_frame(1'b0, MODE_STRAIGHT[1:0], 16'd14);         // past limit, turn
      repeat (2) send_frame(1'b0, MODE_CROSS[1:0], 16'd0);
      repeat (3) send_frame(1'b0, MODE_CROSS[1:0], 16'd0);  // cross becomes official
      send_frame(1'b0, MODE_STRAIGHT[1:0], 16'd0);          // held
      send_frame(1'b0, MODE_TURN[1:0], 16'd0);              // held, last frame
      send_frame(1'b0, MODE_STRAIGHT[1:0], 16'd0);          // voting again
      run_random_traffic(150);
      drain();

      // Reset values
      c = '{6'd10, 6'd30, 8'd20, 7'd80, 7'd30, 16'd13, 8'd20};
      apply_settings(c);
      run_random_traffic(PHASE_FRAMES);
      drain();

      // All zero
      c = '0;
      apply_settings(c);
      run_random_traffic(120);
      drain();

      // Near maximum, promotion only at the saturated score
      c = '{6'd63, 6'd63, 8'd255, 7'd127, 7'd126, 16'hFFFF, 8'd255};
      apply_settings(c);
      run_random_traffic(PHASE_FRAMES);
      drain();

      // Award above the ceiling, no hold, zero limits
      c = '{6'd63, 6'd1, 8'd0, 7'd20, 7'd10, 16'd0, 8'd0};
      apply_settings(c);
      run_random_traffic(PHASE_FRAMES);
      drain();

      repeat (3) begin
         apply_settings(random_settings());
         run_random_traffic(PHASE_FRAMES);
         drain();
      end

      // Last part at full rate on both sides
      idle_enabled = 1'b0;
      apply_settings(random_settings());
      run_random_traffic(PHASE_FRAMES);
      drain();
      repeat (SETTLE_CYCLES) @(negedge clock);

      if (sb.pending_reports.size() != 0)
         sb.report_mismatch($sformatf("%0d responses never arrived",
                                      sb.pending_reports.size()));
      $display("Run covered %0d requests over %0d register settings, %0d long hold-offs.",
               req_count, phase_count, hold_off_count);
      $display("Responses checked: %0d, mismatches: %0d.", sb.checked, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("track_mode_vote_filter_core verification clean");
      end else begin
         $display("track_mode_vote_filter_core verification failed");
      end
      $finish;
   end

endmodule
